// File: design/vang_pkg.sv
// Shared types, constants and the arc tangent table for the vector angle block.
package vang_pkg;

  localparam int NW       = 124;  // normalized product width
  localparam int RT_W     = 62;   // square root width
  localparam int REM_W    = 66;   // square root remainder width
  localparam int CW       = 64;   // CORDIC x/y width
  localparam int ZW       = 34;   // CORDIC angle accumulator width
  localparam int CNT_W    = 7;    // step counter width
  localparam int CORD_N   = 30;   // CORDIC iterations
  localparam int IDX_W    = 5;

  typedef enum logic [3:0] {
    S_ACC, S_CHECK, S_MULP, S_LOADD, S_MULD, S_SUB,
    S_NORM, S_SQRT, S_CLOAD, S_CORD, S_DONE
  } state_t;

  typedef struct packed {
    logic             mul_load_p;
    logic             mul_load_d;
    logic             mul_step;
    logic             sub_load;
    logic             norm_step;
    logic             sqrt_load;
    logic             sqrt_step;
    logic             cordic_load;
    logic             cordic_step;
    logic [IDX_W-1:0] cord_idx;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic too_long;
    logic degen;
    logic norm_done;
    logic out_free;
  } sts_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [29:0] atan_val(input logic [IDX_W-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// File: design/vang_ctrl.sv
// Sequencer for the vector angle block: accumulate, then multiply, normalize, root, CORDIC.
module vang_ctrl #(
  parameter int SUM_W = 42
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  vang_pkg::sts_t  sts,
  output logic            acc_en,
  output vang_pkg::cmd_t  cmd
);

  vang_pkg::state_t state_r, state_nxt;
  logic [vang_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [vang_pkg::CNT_W-1:0] MUL_END  = vang_pkg::CNT_W'(SUM_W - 1);
  localparam logic [vang_pkg::CNT_W-1:0] SQRT_END = vang_pkg::CNT_W'(vang_pkg::RT_W - 1);
  localparam logic [vang_pkg::CNT_W-1:0] CORD_END = vang_pkg::CNT_W'(vang_pkg::CORD_N - 1);

  assign in_ready = (state_r == vang_pkg::S_ACC);
  assign acc_en   = in_valid & in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vang_pkg::S_ACC:   if (acc_en && in_last) state_nxt = vang_pkg::S_CHECK;
      vang_pkg::S_CHECK: begin
        if (sts.too_long || sts.degen) state_nxt = vang_pkg::S_DONE;
        else state_nxt = vang_pkg::S_MULP;
      end
      vang_pkg::S_MULP:  if (cnt_r == MUL_END) state_nxt = vang_pkg::S_LOADD;
      vang_pkg::S_LOADD: state_nxt = vang_pkg::S_MULD;
      vang_pkg::S_MULD:  if (cnt_r == MUL_END) state_nxt = vang_pkg::S_SUB;
      vang_pkg::S_SUB:   state_nxt = vang_pkg::S_NORM;
      vang_pkg::S_NORM:  if (sts.norm_done) state_nxt = vang_pkg::S_SQRT;
      vang_pkg::S_SQRT:  if (cnt_r == SQRT_END) state_nxt = vang_pkg::S_CLOAD;
      vang_pkg::S_CLOAD: state_nxt = vang_pkg::S_CORD;
      vang_pkg::S_CORD:  if (cnt_r == CORD_END) state_nxt = vang_pkg::S_DONE;
      vang_pkg::S_DONE:  if (sts.out_free) state_nxt = vang_pkg::S_ACC;
      default:           state_nxt = vang_pkg::S_ACC;
    endcase
  end

  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;

  always_comb begin
    cmd          = '0;
    cmd.cord_idx = cnt_r[vang_pkg::IDX_W-1:0];
    unique case (state_r)
      vang_pkg::S_CHECK: cmd.mul_load_p = !(sts.too_long || sts.degen);
      vang_pkg::S_MULP:  cmd.mul_step   = 1'b1;
      vang_pkg::S_LOADD: cmd.mul_load_d = 1'b1;
      vang_pkg::S_MULD:  cmd.mul_step   = 1'b1;
      vang_pkg::S_SUB:   cmd.sub_load   = 1'b1;
      vang_pkg::S_NORM: begin
        cmd.norm_step = !sts.norm_done;
        cmd.sqrt_load = sts.norm_done;
      end
      vang_pkg::S_SQRT:  cmd.sqrt_step   = 1'b1;
      vang_pkg::S_CLOAD: cmd.cordic_load = 1'b1;
      vang_pkg::S_CORD:  cmd.cordic_step = 1'b1;
      vang_pkg::S_DONE:  cmd.out_load    = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vang_pkg::S_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: design/vang_dp.sv
// Datapath: running sums, shift-add multiplier, normalizer, square root, CORDIC.
module vang_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16,
  parameter int MAX_LEN     = 1024,
  parameter int SUM_W       = 42
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SAMPLE_BITS-1:0] in_elem_a,
  input  logic [SAMPLE_BITS-1:0] in_elem_b,
  input  logic                   acc_en,
  input  vang_pkg::cmd_t         cmd,
  output vang_pkg::sts_t         sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [ANGLE_BITS-1:0]  out_angle,
  output logic                   out_degenerate,
  output logic                   out_overflow
);

  localparam int PC_W = $clog2(MAX_LEN + 1);
  localparam int PW   = 2 * SAMPLE_BITS;
  localparam int MW   = 2 * SUM_W;

  logic [SUM_W-1:0] dot_r, na_r, nb_r;
  logic [PC_W-1:0]  pcnt_r;
  logic             too_long_r;

  logic signed [PW-1:0] p_ab, p_aa, p_bb;
  assign p_ab = $signed(in_elem_a) * $signed(in_elem_b);
  assign p_aa = $signed(in_elem_a) * $signed(in_elem_a);
  assign p_bb = $signed(in_elem_b) * $signed(in_elem_b);

  logic clr;
  assign clr = cmd.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      dot_r      <= '0;
      na_r       <= '0;
      nb_r       <= '0;
      pcnt_r     <= '0;
      too_long_r <= 1'b0;
    end else if (acc_en) begin
      if (pcnt_r < PC_W'(MAX_LEN)) begin
        dot_r  <= dot_r + {{(SUM_W-PW){p_ab[PW-1]}}, p_ab};
        na_r   <= na_r + {{(SUM_W-PW){1'b0}}, p_aa};
        nb_r   <= nb_r + {{(SUM_W-PW){1'b0}}, p_bb};
        pcnt_r <= pcnt_r + 1'b1;
      end else begin
        too_long_r <= 1'b1;
      end
    end
  end

  logic             neg;
  logic [SUM_W-1:0] mag;
  assign neg = dot_r[SUM_W-1];
  assign mag = neg ? (~dot_r + 1'b1) : dot_r;

  // shift-add multiplier, one multiplier bit per cycle
  logic [SUM_W-1:0] ma_r;
  logic [MW-1:0]    mb_r, macc_r, prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_load_p) begin
      ma_r   <= na_r;
      mb_r   <= {{SUM_W{1'b0}}, nb_r};
      macc_r <= '0;
    end else if (cmd.mul_load_d) begin
      prod_r <= macc_r;
      ma_r   <= mag;
      mb_r   <= {{SUM_W{1'b0}}, mag};
      macc_r <= '0;
    end else if (cmd.mul_step) begin
      if (ma_r[0]) macc_r <= macc_r + mb_r;
      ma_r <= ma_r >> 1;
      mb_r <= mb_r << 1;
    end
  end

  // normalize, then integer square root two bits a step
  logic [vang_pkg::NW-1:0]    pn_r, dn_r;
  logic signed [vang_pkg::CW-1:0] x_r, y_r;
  logic [vang_pkg::REM_W-1:0] rem_r;
  logic [vang_pkg::RT_W-1:0]  root_r;
  logic signed [vang_pkg::ZW-1:0] z_r;

  logic [vang_pkg::REM_W-1:0] rem_sh, trial;
  assign rem_sh = {rem_r[vang_pkg::REM_W-3:0], dn_r[vang_pkg::NW-1 -: 2]};
  assign trial  = {{(vang_pkg::REM_W-vang_pkg::RT_W-2){1'b0}}, root_r, 2'b01};

  logic signed [vang_pkg::CW-1:0] xs, ys;
  logic [29:0] atv;
  assign xs  = x_r >>> cmd.cord_idx;
  assign ys  = y_r >>> cmd.cord_idx;
  assign atv = vang_pkg::atan_val(cmd.cord_idx);

  always_ff @(posedge clk) begin
    if (cmd.sub_load) begin
      pn_r <= vang_pkg::NW'(prod_r);
      dn_r <= (macc_r <= prod_r) ? vang_pkg::NW'(prod_r - macc_r) : '0;
      x_r  <= vang_pkg::CW'(mag);
    end else if (cmd.norm_step) begin
      pn_r <= pn_r << 2;
      dn_r <= dn_r << 2;
      x_r  <= x_r << 1;
    end else if (cmd.sqrt_load) begin
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      dn_r <= dn_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[vang_pkg::RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[vang_pkg::RT_W-2:0], 1'b0};
      end
    end else if (cmd.cordic_load) begin
      x_r <= x_r >>> 2;
      y_r <= vang_pkg::CW'(root_r >> 2);
      z_r <= '0;
    end else if (cmd.cordic_step) begin
      if (!y_r[vang_pkg::CW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + $signed({{(vang_pkg::ZW-30){1'b0}}, atv});
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - $signed({{(vang_pkg::ZW-30){1'b0}}, atv});
      end
    end
  end

  // clamp, fold for negative dot, round to output units
  logic [31:0] zc, theta;
  logic [32:0] rnd, ang_full;
  localparam logic [32:0] FULL = 33'd1 << (ANGLE_BITS - 1);

  always_comb begin
    if (z_r[vang_pkg::ZW-1]) zc = '0;
    else if (z_r > $signed(vang_pkg::ZW'(34'd1 << 30))) zc = 32'd1 << 30;
    else zc = z_r[31:0];
    theta    = neg ? ((32'd1 << 31) - zc) : zc;
    rnd      = ({1'b0, theta} + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    ang_full = (rnd > FULL) ? FULL : rnd;
  end

  logic degen;
  assign degen = (na_r == '0) || (nb_r == '0);

  logic out_valid_r;
  logic [ANGLE_BITS-1:0] angle_r;
  logic degen_r, ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      angle_r <= (too_long_r || degen) ? '0 : ang_full[ANGLE_BITS-1:0];
      degen_r <= !too_long_r && degen;
      ovf_r   <= too_long_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_angle      = angle_r;
  assign out_degenerate = degen_r;
  assign out_overflow   = ovf_r;

  assign sts.too_long  = too_long_r;
  assign sts.degen     = degen;
  assign sts.norm_done = (pn_r[vang_pkg::NW-1 -: 2] != 2'b00);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// File: design/vector_angle.sv
// Top level of the vector angle block: streams element pairs, returns the angle.
//
//   channel | ports                                    | dir
//   in      | in_valid/in_ready, elem_a, elem_b, last  | input word per element pair
//   out     | out_valid/out_ready, angle, degenerate,  | one word per vector pair
//           | overflow                                 |
//
// Pairs are taken one per cycle while accumulating. After the last pair the
// block is busy in the bit-serial multiplier, the normalizer, the square root
// and CORDIC, in that order. Overflowed or zero-norm vectors skip these steps
// and go from the check straight to the result.
// rst_n is synchronous and clears the sums and the sequencer.
// A held result stalls only the next vector's finish, not its accumulation.
module vector_angle #(
  parameter int MAX_LEN     = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_elem_a,
  input  logic [SAMPLE_BITS-1:0] in_elem_b,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ANGLE_BITS-1:0]  out_angle,
  output logic                   out_degenerate,
  output logic                   out_overflow
);

  localparam int SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_LEN);

  vang_pkg::cmd_t cmd;
  vang_pkg::sts_t sts;
  logic           acc_en;

  vang_ctrl #(.SUM_W(SUM_W)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .acc_en   (acc_en),
    .cmd      (cmd)
  );

  vang_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ANGLE_BITS  (ANGLE_BITS),
    .MAX_LEN     (MAX_LEN),
    .SUM_W       (SUM_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_elem_a      (in_elem_a),
    .in_elem_b      (in_elem_b),
    .acc_en         (acc_en),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_angle      (out_angle),
    .out_degenerate (out_degenerate),
    .out_overflow   (out_overflow)
  );

endmodule
